>>> sv/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

package u2u_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] REPL_UNIT = 16'hFFFD;

  // One decoded byte's worth of output: rep_cnt replacement units, then
  // tail_cnt units from tail0/tail1.
  typedef struct packed {
    logic [2:0]  rep_cnt;
    logic [1:0]  tail_cnt;
    logic [15:0] tail0;
    logic [15:0] tail1;
    logic        last;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

endpackage

>>> sv/u2u_if.sv
// Stream interfaces for the byte input and the code unit output.
`timescale 1ns / 1ps

interface u2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       string_end;

  modport source (output valid, output byte_in, output string_end, input ready);
  modport sink (input valid, input byte_in, input string_end, output ready);
endinterface

interface u2u_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_last;

  modport source (output valid, output code_unit, output unit_last, input ready);
  modport sink (input valid, input code_unit, input unit_last, output ready);
endinterface

>>> sv/u2u_front.sv
// Front end: UTF-8 decode state and per-byte job builder.
`timescale 1ns / 1ps

module u2u_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      byte_in_i,
  input  logic            string_end_i,
  output logic            push_o,
  output u2u_pkg::job_t   job_o
);
  import u2u_pkg::*;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_e;

  localparam logic [20:0] MAX_POINT      = 21'h10FFFF;
  localparam logic [20:0] SURR_LOW_BOUND = 21'h00D800;
  localparam logic [20:0] SURR_HI_BOUND  = 21'h00DFFF;
  localparam logic [20:0] PLANE_ONE      = 21'h010000;
  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;

  function automatic lead_e classify_lead(input logic [7:0] b);
    lead_e cls;
    priority casez (b)
      8'b0???????: cls = LEAD_ASCII;
      8'b110?????: cls = LEAD_TWO;
      8'b1110????: cls = LEAD_THREE;
      8'b11110???: cls = LEAD_FOUR;
      default:     cls = LEAD_BAD;
    endcase
    return cls;
  endfunction

  logic [20:0] point_q, point_d;
  logic [2:0]  exp_len_q, exp_len_d;
  logic [1:0]  held_q, held_d;

  logic        is_cont;
  logic [20:0] shifted;
  logic [20:0] offset;
  logic [1:0]  held_inc;
  logic        bad_point;
  lead_e       lead_cls;
  job_t        job;

  assign is_cont  = (byte_in_i[7:6] == 2'b10);
  assign shifted  = {point_q[14:0], byte_in_i[5:0]};
  assign offset   = shifted - PLANE_ONE;
  assign held_inc = held_q + 2'd1;
  assign lead_cls = classify_lead(byte_in_i);

  always_comb begin
    bad_point = 1'b0;
    if (exp_len_q == 3'd2 && shifted < 21'h80)  bad_point = 1'b1;
    if (exp_len_q == 3'd3 && shifted < 21'h800) bad_point = 1'b1;
    if (exp_len_q == 3'd4 && shifted < PLANE_ONE) bad_point = 1'b1;
    if (shifted > MAX_POINT) bad_point = 1'b1;
    if (shifted >= SURR_LOW_BOUND && shifted <= SURR_HI_BOUND) bad_point = 1'b1;
  end

  always_comb begin
    job       = '0;
    point_d   = point_q;
    exp_len_d = exp_len_q;
    held_d    = held_q;
    if (exp_len_q != 3'd0 && is_cont) begin
      point_d = shifted;
      held_d  = held_inc;
      if (({1'b0, held_inc} + 3'd1) >= exp_len_q) begin
        point_d   = '0;
        exp_len_d = '0;
        held_d    = '0;
        if (bad_point) begin
          job.rep_cnt = {1'b0, held_inc} + 3'd1;
        end else if (shifted < PLANE_ONE) begin
          job.tail_cnt = 2'd1;
          job.tail0    = shifted[15:0];
        end else begin
          job.tail_cnt = 2'd2;
          job.tail0    = HIGH_SURR_BASE + {6'd0, offset[19:10]};
          job.tail1    = LOW_SURR_BASE + {6'd0, offset[9:0]};
        end
      end else if (string_end_i) begin
        // cut off at end of string
        job.rep_cnt = {1'b0, held_inc} + 3'd1;
        point_d     = '0;
        exp_len_d   = '0;
        held_d      = '0;
      end
    end else begin
      // broken sequence flushes first, then the byte is a fresh lead
      if (exp_len_q != 3'd0) job.rep_cnt = {1'b0, held_q} + 3'd1;
      point_d   = '0;
      exp_len_d = '0;
      held_d    = '0;
      unique case (lead_cls)
        LEAD_ASCII: begin
          job.tail_cnt = 2'd1;
          job.tail0    = {8'h00, byte_in_i};
        end
        LEAD_TWO: begin
          point_d   = {16'd0, byte_in_i[4:0]};
          exp_len_d = 3'd2;
        end
        LEAD_THREE: begin
          point_d   = {17'd0, byte_in_i[3:0]};
          exp_len_d = 3'd3;
        end
        LEAD_FOUR: begin
          point_d   = {18'd0, byte_in_i[2:0]};
          exp_len_d = 3'd4;
        end
        default: begin
          job.rep_cnt = job.rep_cnt + 3'd1;
        end
      endcase
      if (string_end_i && exp_len_d != 3'd0) begin
        job.rep_cnt = job.rep_cnt + 3'd1;
        point_d     = '0;
        exp_len_d   = '0;
        held_d      = '0;
      end
    end
    job.last = string_end_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_q   <= '0;
      exp_len_q <= '0;
      held_q    <= '0;
    end else if (accept_i) begin
      point_q   <= point_d;
      exp_len_q <= exp_len_d;
      held_q    <= held_d;
    end
  end

  assign push_o = accept_i && (job.rep_cnt != 3'd0 || job.tail_cnt != 2'd0);
  assign job_o  = job;

endmodule

>>> sv/u2u_queue.sv
// Short job queue between the decode front end and the unit serializer.
`timescale 1ns / 1ps

module u2u_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u2u_pkg::job_t     job_i,
  input  logic              pop_i,
  output logic              full_o,
  output u2u_pkg::q_head_t  head_o
);
  import u2u_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign full_o       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.job   = mem_q[rd_ptr_q];

endmodule

>>> sv/u2u_back.sv
// Back end: head job units to the output register, one per cycle unless stalled.
`timescale 1ns / 1ps

module u2u_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  u2u_pkg::q_head_t  head_i,
  output logic              pop_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [15:0]       code_unit_o,
  output logic              unit_last_o
);
  import u2u_pkg::*;

  logic [1:0]  idx_q;
  logic        out_valid_q;
  logic [15:0] code_q;
  logic        last_q;

  logic [2:0]  total;
  logic [2:0]  idx_ext;
  logic        job_done;
  logic        load;
  logic [15:0] unit_sel;

  assign total    = head_i.job.rep_cnt + {1'b0, head_i.job.tail_cnt};
  assign idx_ext  = {1'b0, idx_q};
  assign job_done = (idx_ext + 3'd1) == total;
  assign load     = head_i.valid && (!out_valid_q || out_ready_i);
  assign pop_o    = load && job_done;

  always_comb begin
    priority if (idx_ext < head_i.job.rep_cnt) begin
      unit_sel = REPL_UNIT;
    end else if (idx_ext == head_i.job.rep_cnt) begin
      unit_sel = head_i.job.tail0;
    end else begin
      unit_sel = head_i.job.tail1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= job_done ? 2'd0 : idx_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q <= unit_sel;
      last_q <= head_i.job.last && job_done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign code_unit_o = code_q;
  assign unit_last_o = last_q;

endmodule

>>> sv/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder top level: front decoder, job queue, unit serializer.
// A byte's job is queued, then loaded unit by unit into the output register.
// Throughput: one byte per cycle in while the queue has room, one unit per cycle
//   out while ready; a k-unit byte holds the serializer, absorbed by a 2-job queue.
// Reset: rst_ni async active low clears decode state, queue and output valid.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  u2u_in_if.sink     in_i,
  u2u_out_if.source  out_o
);
  import u2u_pkg::*;

  logic    accept;
  logic    push;
  logic    pop;
  logic    q_full;
  job_t    job;
  q_head_t head;

  // Input word is taken whenever the queue has room; bytes that produce no
  // unit (lead or middle continuation) never enter the queue.
  assign in_i.ready = !q_full;
  assign accept     = in_i.valid && in_i.ready;

  u2u_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .byte_in_i    (in_i.byte_in),
    .string_end_i (in_i.string_end),
    .push_o       (push),
    .job_o        (job)
  );

  u2u_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  // Serializer emits replacement units first, then the decoded tail units.
  u2u_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .code_unit_o (out_o.code_unit),
    .unit_last_o (out_o.unit_last)
  );

  // Last byte of a string always produces at least one unit.
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.string_end) |-> push)
    else $error("last byte of string produced no job");

  // A job holds one to four units.
  a_job_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ((4'(job.rep_cnt) + 4'(job.tail_cnt)) != 4'd0 &&
              (4'(job.rep_cnt) + 4'(job.tail_cnt)) <= 4'd4))
    else $error("job unit count out of range");

  // A queued job with a free output slot shows a word on the next cycle.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head.valid && (!out_o.valid || out_o.ready)) |=> out_o.valid)
    else $error("serializer failed to load output word");

  // Only the front end feeds the queue, and only when it has room.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job pushed into full queue");

endmodule

>>> bench/transcode_checker.sv
// Scoreboard for the UTF-8 to UTF-16 transcoder: predicts code units and checks the output.
`timescale 1ns / 1ps

module transcode_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] out_unit_i,
  input  logic        out_last_i,
  output int unsigned fault_count_o,
  output int unsigned units_pending_o
);
  import u2u_pkg::*;

  localparam logic [20:0] MAX_POINT   = 21'h10FFFF;
  localparam logic [20:0] PLANE_ONE   = 21'h010000;
  localparam logic [20:0] SURR_FIRST  = 21'h00D800;
  localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
  localparam logic [15:0] HIGH_BASE   = 16'hD800;
  localparam logic [15:0] LOW_BASE    = 16'hDC00;
  localparam int          UNITS_LIMIT = 4;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_last;
  } utf16_word_t;

  // decoder state
  logic [20:0] point_acc;
  logic [2:0]  seq_len;
  logic [1:0]  conts_held;

  utf16_word_t burst_units [UNITS_LIMIT];
  int          burst_len;
  utf16_word_t expected_units [$];
  int unsigned faults;

  assign fault_count_o   = faults;
  assign units_pending_o = expected_units.size();

  function automatic void emit_unit(input logic [15:0] u);
    if (burst_len < UNITS_LIMIT) begin
      burst_units[burst_len] = '{code_unit: u, unit_last: 1'b0};
      burst_len++;
    end
  endfunction

  function automatic void drop_sequence();
    point_acc  = '0;
    seq_len    = '0;
    conts_held = '0;
  endfunction

  // lead plus every held continuation becomes one replacement each
  function automatic void flush_broken();
    repeat (int'(conts_held) + 1) emit_unit(REPL_UNIT);
    drop_sequence();
  endfunction

  function automatic void open_lead(input logic [7:0] b);
    if (b[7] == 1'b0) begin
      emit_unit({8'h00, b});
    end else if (b[7:5] == 3'b110) begin
      point_acc  = {16'h0000, b[4:0]};
      seq_len    = 3'd2;
      conts_held = '0;
    end else if (b[7:4] == 4'b1110) begin
      point_acc  = {17'h00000, b[3:0]};
      seq_len    = 3'd3;
      conts_held = '0;
    end else if (b[7:3] == 5'b11110) begin
      point_acc  = {18'h00000, b[2:0]};
      seq_len    = 3'd4;
      conts_held = '0;
    end else begin
      emit_unit(REPL_UNIT);
    end
  endfunction

  function automatic void close_point();
    logic [20:0] cp;
    logic [20:0] off;
    logic        bad;
    cp  = point_acc;
    bad = 1'b0;
    if (seq_len == 3'd2 && cp < 21'h80)  bad = 1'b1;
    if (seq_len == 3'd3 && cp < 21'h800) bad = 1'b1;
    if (seq_len == 3'd4 && cp < PLANE_ONE) bad = 1'b1;
    if (cp > MAX_POINT) bad = 1'b1;
    if (cp >= SURR_FIRST && cp <= SURR_LAST) bad = 1'b1;
    if (bad) begin
      flush_broken();
      return;
    end
    if (cp < PLANE_ONE) begin
      emit_unit(cp[15:0]);
    end else begin
      off = cp - PLANE_ONE;
      emit_unit(HIGH_BASE + {6'b0, off[19:10]});
      emit_unit(LOW_BASE + {6'b0, off[9:0]});
    end
    drop_sequence();
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    burst_len = 0;
    if (seq_len != '0) begin
      if (b[7:6] == 2'b10) begin
        point_acc = {point_acc[14:0], b[5:0]};
        conts_held++;
        if (int'(conts_held) + 1 >= int'(seq_len)) close_point();
      end else begin
        // sequence broken: flush it, then this byte starts over as a lead
        flush_broken();
        open_lead(b);
      end
    end else begin
      open_lead(b);
    end
    if (fin) begin
      if (seq_len != '0) flush_broken();
      if (burst_len > 0) burst_units[burst_len - 1].unit_last = 1'b1;
    end
    for (int i = 0; i < burst_len; i++) expected_units = {expected_units, burst_units[i]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    utf16_word_t want;
    if (!rst_ni) begin
      drop_sequence();
      expected_units.delete();
      faults = 0;
    end else begin
      if (in_valid_i && in_ready_i) decode_byte(in_byte_i, in_end_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_units.size() == 0) begin
          $error("unexpected word: code_unit %h unit_last %b", out_unit_i, out_last_i);
          faults++;
        end else begin
          want = expected_units[0];
          expected_units.delete(0);
          if (out_unit_i !== want.code_unit) begin
            $error("code_unit: expected %h, actual %h", want.code_unit, out_unit_i);
            faults++;
          end
          if (out_last_i !== want.unit_last) begin
            $error("unit_last: expected %b, actual %b", want.unit_last, out_last_i);
            faults++;
          end
        end
      end
    end
  end

endmodule

>>> bench/tb_top.sv
// Testbench top for the UTF-8 to UTF-16 transcoder: clock, reset, byte strings, verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_BYTES = 420;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 12;
  // leave a safe margin after the backlog drains
  localparam int DRAIN_CYCLES = 16;

  // kinds of malformed input mixed into the random strings
  typedef enum int {
    RAW_BYTE,
    OVERLONG,
    SURROGATE,
    OUT_OF_RANGE,
    TRUNCATED,
    STRAY_CONT
  } flaw_e;

  logic clk_i;
  logic rst_ni;

  u2u_in_if  in_w ();
  u2u_out_if out_w ();

  int unsigned fault_count;
  int unsigned units_pending;
  int          cycle_count;
  int          bytes_sent;
  logic        steady;       // no idling on either side while set
  logic [7:0]  text_bytes [$];

  utf8_to_utf16_transcoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  transcode_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_w.valid),
    .in_ready_i      (in_w.ready),
    .in_byte_i       (in_w.byte_in),
    .in_end_i        (in_w.string_end),
    .out_valid_i     (out_w.valid),
    .out_ready_i     (out_w.ready),
    .out_unit_i      (out_w.code_unit),
    .out_last_i      (out_w.unit_last),
    .fault_count_o   (fault_count),
    .units_pending_o (units_pending)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("utf8_to_utf16_transcoder: mismatch");
      $finish;
    end
  end

  // receiver stalls at random, except during the steady stretch
  always @(posedge clk_i) begin
    out_w.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // One byte per handshake. ready only moves at the rising edge, so the value
  // seen at the falling edge is the one the next edge will use.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    logic took;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_w.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_w.valid      <= 1'b1;
    in_w.byte_in    <= b;
    in_w.string_end <= fin;
    do begin
      @(negedge clk_i);
      took = in_w.ready;
      @(posedge clk_i);
    end while (!took);
    bytes_sent++;
  endtask

  // the flag goes on the last byte of the string
  task automatic send_string();
    for (int i = 0; i < text_bytes.size(); i++) begin
      send_byte(text_bytes[i], i == text_bytes.size() - 1);
    end
  endtask

  function automatic void append_byte(input logic [7:0] b);
    text_bytes = {text_bytes, b};
  endfunction

  // Encode cp in len bytes with no range checks, so overlong forms,
  // surrogates and values past U+10FFFF come out just as easily.
  function automatic void put_point(input logic [20:0] cp, input int len);
    case (len)
      2: begin
        append_byte({3'b110, cp[10:6]});
        append_byte({2'b10, cp[5:0]});
      end
      3: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
      default: begin
        append_byte({5'b11110, cp[20:18]});
        append_byte({2'b10, cp[17:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // Mostly well-formed characters of every length with random content;
  // about one character in seven is damaged in some way.
  task automatic build_random_string();
    int          nchar;
    int          pick;
    logic [20:0] cp;
    text_bytes.delete();
    nchar = $urandom_range(1, 6);
    repeat (nchar) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        // ASCII, zero byte included now and then
        append_byte(8'($urandom_range(0, 127)));
      end else if (pick < 42) begin
        put_point(21'($urandom_range(32'h80, 32'h7FF)), 2);
      end else if (pick < 66) begin
        cp = 21'($urandom_range(32'h800, 32'hFFFF));
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h800;
        put_point(cp, 3);
      end else if (pick < 86) begin
        put_point(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
      end else begin
        case (flaw_e'($urandom_range(0, 5)))
          RAW_BYTE:     append_byte(8'($urandom_range(0, 255)));
          OVERLONG:     put_point(21'($urandom_range(0, 127)), $urandom_range(2, 4));
          SURROGATE:    put_point(21'($urandom_range(32'hD800, 32'hDFFF)), 3);
          OUT_OF_RANGE: put_point(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
          TRUNCATED: begin
            put_point(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
            repeat ($urandom_range(1, 3)) void'(text_bytes.pop_back());
          end
          default:      append_byte(8'($urandom_range(8'h80, 8'hBF)));
        endcase
      end
    end
  endtask

  initial begin
    int random_start;
    in_w.valid      = 1'b0;
    in_w.byte_in    = 8'h00;
    in_w.string_end = 1'b0;
    out_w.ready     = 1'b0;
    steady          = 1'b0;
    cycle_count     = 0;
    bytes_sent      = 0;
    rst_ni          = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed strings
    // ASCII edge, zero byte, then a two-byte character
    text_bytes = '{8'h7F, 8'h00, 8'hC3, 8'hA9};
    send_string();
    // U+1F600, needs a surrogate pair
    text_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80};
    send_string();
    // encoded surrogate, overlong two-byte NUL, stray continuation, bad lead
    text_bytes = '{8'hED, 8'hA0, 8'h80, 8'hC0, 8'h80, 8'h80, 8'hFF};
    send_string();
    // just past U+10FFFF
    text_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_string();
    // four-byte sequence broken by ASCII: three replacements, then 'A'
    text_bytes = '{8'hF0, 8'h90, 8'h82, 8'h41};
    send_string();
    // three-byte sequence cut off by the end of the string
    text_bytes = '{8'hE2, 8'h82};
    send_string();

    // random strings, with a stretch of back-to-back traffic in the middle
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      steady = (bytes_sent - random_start >= 150) && (bytes_sent - random_start < 250);
      build_random_string();
      send_string();
    end
    in_w.valid <= 1'b0;
    steady = 1'b0;

    // let the checker book the last byte before looking at the backlog
    @(posedge clk_i);
    while (units_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("utf8_to_utf16_transcoder: match");
    end else begin
      $display("utf8_to_utf16_transcoder: mismatch");
    end
    $finish;
  end

endmodule
